@@ sv/alu8_pkg.sv @@
// Shared types for the 8-bit accumulator ALU with flags.
// Holds the operation codes and the flag record used by the core and the top level.
// No dependencies.
package alu8_pkg;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC8  = 5'd8,
		OP_DEC8  = 5'd9,
		OP_INC16 = 5'd10,
		OP_DEC16 = 5'd11,
		OP_ADDHL = 5'd12,
		OP_ADDSP = 5'd13,
		OP_CPL   = 5'd14,
		OP_RRA   = 5'd15,
		OP_RLA   = 5'd16,
		OP_RRCA  = 5'd17,
		OP_RLCA  = 5'd18,
		OP_DAA   = 5'd19
	} alu_op_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	localparam logic [7:0] DAA_LO_ADJ = 8'h06;
	localparam logic [7:0] DAA_HI_ADJ = 8'h60;
	localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
	localparam logic [7:0] BCD_BYTE_MAX = 8'h99;

endpackage

@@ sv/alu8_core.sv @@
// Combinational datapath of the accumulator ALU: next accumulator, next flags and side results.
// Depends on alu8_pkg for the operation codes and the flag record.
module alu8_core
	import alu8_pkg::*;
(
	input  logic [4:0]  func,
	input  logic [7:0]  operand8,
	input  logic        target_is_acc,
	input  logic [15:0] word_a,
	input  logic [15:0] word_b,
	input  logic [7:0]  acc,
	input  flags_t      flags,
	output logic [7:0]  acc_nxt,
	output flags_t      flags_nxt,
	output logic [7:0]  result8,
	output logic [15:0] result16
);

	alu_op_t     op;
	logic        carry_in;
	logic [8:0]  sum9;
	logic [4:0]  hsum5;
	logic [8:0]  diff9;
	logic [4:0]  hdiff5;
	logic [7:0]  idv;
	logic [7:0]  inc8;
	logic [7:0]  dec8;
	logic [16:0] hl17;
	logic [12:0] hl13;
	logic [15:0] sp16;
	logic [8:0]  spc9;
	logic [4:0]  sph5;
	logic        daa_lo;
	logic        daa_hi;
	logic [7:0]  daa_sub_adj;
	logic [7:0]  daa_add_adj;
	logic [7:0]  daa_val;

	assign op       = alu_op_t'(func);
	assign carry_in = ((op == OP_ADC) || (op == OP_SBC)) ? flags.c : 1'b0;

	assign sum9   = {1'b0, acc} + {1'b0, operand8} + {8'd0, carry_in};
	assign hsum5  = {1'b0, acc[3:0]} + {1'b0, operand8[3:0]} + {4'd0, carry_in};
	assign diff9  = {1'b0, acc} - {1'b0, operand8} - {8'd0, carry_in};
	assign hdiff5 = {1'b0, acc[3:0]} - {1'b0, operand8[3:0]} - {4'd0, carry_in};

	assign idv  = target_is_acc ? acc : operand8;
	assign inc8 = idv + 8'd1;
	assign dec8 = idv - 8'd1;

	assign hl17 = {1'b0, word_a} + {1'b0, word_b};
	assign hl13 = {1'b0, word_a[11:0]} + {1'b0, word_b[11:0]};

	assign sp16 = word_a + {{8{operand8[7]}}, operand8};
	assign spc9 = {1'b0, word_a[7:0]} + {1'b0, operand8};
	assign sph5 = {1'b0, word_a[3:0]} + {1'b0, operand8[3:0]};

	assign daa_lo      = flags.h || (acc[3:0] > BCD_DIGIT_MAX);
	assign daa_hi      = flags.c || (acc > BCD_BYTE_MAX);
	assign daa_sub_adj = (flags.h ? DAA_LO_ADJ : 8'd0) | (flags.c ? DAA_HI_ADJ : 8'd0);
	assign daa_add_adj = (daa_lo ? DAA_LO_ADJ : 8'd0) | (daa_hi ? DAA_HI_ADJ : 8'd0);
	assign daa_val     = flags.n ? (acc - daa_sub_adj) : (acc + daa_add_adj);

	always_comb begin
		acc_nxt   = acc;
		flags_nxt = flags;
		result8   = 8'd0;
		result16  = 16'd0;
		case (op)
			OP_ADD, OP_ADC: begin
				acc_nxt   = sum9[7:0];
				flags_nxt = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				if (op != OP_CP) begin
					acc_nxt = diff9[7:0];
				end
				flags_nxt = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: hdiff5[4], c: diff9[8]};
			end
			OP_AND: begin
				acc_nxt   = acc & operand8;
				flags_nxt = '{z: ((acc & operand8) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			OP_XOR: begin
				acc_nxt   = acc ^ operand8;
				flags_nxt = '{z: ((acc ^ operand8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_OR: begin
				acc_nxt   = acc | operand8;
				flags_nxt = '{z: ((acc | operand8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_INC8: begin
				flags_nxt.z = (inc8 == 8'd0);
				flags_nxt.n = 1'b0;
				flags_nxt.h = (idv[3:0] == 4'hF);
				if (target_is_acc) begin
					acc_nxt = inc8;
				end else begin
					result8 = inc8;
				end
			end
			OP_DEC8: begin
				flags_nxt.z = (dec8 == 8'd0);
				flags_nxt.n = 1'b1;
				flags_nxt.h = (idv[3:0] == 4'h0);
				if (target_is_acc) begin
					acc_nxt = dec8;
				end else begin
					result8 = dec8;
				end
			end
			OP_INC16: begin
				result16 = word_a + 16'd1;
			end
			OP_DEC16: begin
				result16 = word_a - 16'd1;
			end
			OP_ADDHL: begin
				result16    = hl17[15:0];
				flags_nxt.n = 1'b0;
				flags_nxt.h = hl13[12];
				flags_nxt.c = hl17[16];
			end
			OP_ADDSP: begin
				result16  = sp16;
				flags_nxt = '{z: 1'b0, n: 1'b0, h: sph5[4], c: spc9[8]};
			end
			OP_CPL: begin
				acc_nxt     = ~acc;
				flags_nxt.n = 1'b1;
				flags_nxt.h = 1'b1;
			end
			OP_RRA: begin
				acc_nxt   = {flags.c, acc[7:1]};
				flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
			end
			OP_RLA: begin
				acc_nxt   = {acc[6:0], flags.c};
				flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
			end
			OP_RRCA: begin
				acc_nxt   = {acc[0], acc[7:1]};
				flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[0]};
			end
			OP_RLCA: begin
				acc_nxt   = {acc[6:0], acc[7]};
				flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
			end
			OP_DAA: begin
				acc_nxt     = daa_val;
				flags_nxt.z = (daa_val == 8'd0);
				flags_nxt.h = 1'b0;
				if (!flags.n) begin
					flags_nxt.c = daa_hi;
				end
			end
			default: begin
				acc_nxt = acc;
			end
		endcase
	end

endmodule

@@ sv/eight_bit_cpu_alu_with_flags.sv @@
// An accepted transaction is registered in the input stage, then in the result register.
// One transaction per cycle unless stalled; accumulator and flags update as it advances.
// An input stall only arises while the result register is full and the output is stalled.
// Reset clears the accumulator, the flags and both valid bits at once.
// Depends on alu8_pkg and alu8_core.
module eight_bit_cpu_alu_with_flags
	import alu8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  func,
	input  logic [7:0]  operand8,
	input  logic        target_is_acc,
	input  logic [15:0] word_a,
	input  logic [15:0] word_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  acc_out,
	output logic [7:0]  result8,
	output logic [15:0] result16,
	output logic        flag_z,
	output logic        flag_n,
	output logic        flag_h,
	output logic        flag_c
);

	logic        valid_s1;
	logic [4:0]  func_s1;
	logic [7:0]  operand8_s1;
	logic        target_is_acc_s1;
	logic [15:0] word_a_s1;
	logic [15:0] word_b_s1;

	logic [7:0]  acc_q;
	flags_t      flags_q;

	logic        valid_s2;
	logic [7:0]  acc_s2;
	logic [7:0]  result8_s2;
	logic [15:0] result16_s2;
	flags_t      flags_s2;

	logic        out_free;
	logic        advance;
	logic        take_in;
	logic [7:0]  acc_nxt;
	flags_t      flags_nxt;
	logic [7:0]  result8_nxt;
	logic [15:0] result16_nxt;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	alu8_core u_core (
		.func          (func_s1),
		.operand8      (operand8_s1),
		.target_is_acc (target_is_acc_s1),
		.word_a        (word_a_s1),
		.word_b        (word_b_s1),
		.acc           (acc_q),
		.flags         (flags_q),
		.acc_nxt       (acc_nxt),
		.flags_nxt     (flags_nxt),
		.result8       (result8_nxt),
		.result16      (result16_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= 8'd0;
			flags_q  <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				acc_q    <= acc_nxt;
				flags_q  <= flags_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1          <= func;
			operand8_s1      <= operand8;
			target_is_acc_s1 <= target_is_acc;
			word_a_s1        <= word_a;
			word_b_s1        <= word_b;
		end
		if (advance) begin
			acc_s2      <= acc_nxt;
			flags_s2    <= flags_nxt;
			result8_s2  <= result8_nxt;
			result16_s2 <= result16_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign acc_out   = acc_s2;
	assign result8   = result8_s2;
	assign result16  = result16_s2;
	assign flag_z    = flags_s2.z;
	assign flag_n    = flags_s2.n;
	assign flag_h    = flags_s2.h;
	assign flag_c    = flags_s2.c;

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall))
		else $error("input stalled without a blocked result");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(acc_q) && $stable(flags_q)))
		else $error("state changed without a transaction moving to the output");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((acc_s2 == acc_q) && (flags_s2 == flags_q)))
		else $error("presented result disagrees with the held state");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advancing transaction did not reach the result register");
`endif

endmodule
